### design/ipf_pkg.sv
// shared types, codes and reset values for the irrigation pump controller
package ipf_pkg;

    localparam int MoistW    = 7;
    localparam int TimeW     = 32;
    localparam int ModeW     = 3;
    localparam int CodeW     = 3;
    localparam int CfgIdxW   = 2;
    localparam int CfgDataW  = 32;

    localparam logic [MoistW-1:0] MOIST_LOW_RST     = 7'd30;
    localparam logic [MoistW-1:0] MOIST_HIGH_RST    = 7'd70;
    localparam logic [TimeW-1:0]  PUMP_TIMEOUT_RST  = 32'd60000;
    localparam logic [TimeW-1:0]  COOLDOWN_RST      = 32'd300000;

    localparam logic [CfgIdxW-1:0] CFG_MOIST_LOW    = 2'd0;
    localparam logic [CfgIdxW-1:0] CFG_MOIST_HIGH   = 2'd1;
    localparam logic [CfgIdxW-1:0] CFG_PUMP_TIMEOUT = 2'd2;
    localparam logic [CfgIdxW-1:0] CFG_COOLDOWN     = 2'd3;

    typedef enum logic [ModeW-1:0] {
        MODE_UPDATE       = 3'd0,
        MODE_ENTER_ALARM  = 3'd1,
        MODE_START_MANUAL = 3'd2,
        MODE_STOP_MANUAL  = 3'd3,
        MODE_CLEAR_ALARM  = 3'd4
    } mode_t;

    typedef enum logic [6:0] {
        ST_INIT     = 7'b0000001,
        ST_MONITOR  = 7'b0000010,
        ST_AUTO     = 7'b0000100,
        ST_MANUAL   = 7'b0001000,
        ST_COOLDOWN = 7'b0010000,
        ST_ALARM    = 7'b0100000,
        ST_OFFLINE  = 7'b1000000
    } state_t;

    localparam logic [CodeW-1:0] CODE_INIT     = 3'd0;
    localparam logic [CodeW-1:0] CODE_MONITOR  = 3'd1;
    localparam logic [CodeW-1:0] CODE_AUTO     = 3'd2;
    localparam logic [CodeW-1:0] CODE_MANUAL   = 3'd3;
    localparam logic [CodeW-1:0] CODE_COOLDOWN = 3'd4;
    localparam logic [CodeW-1:0] CODE_ALARM    = 3'd5;
    localparam logic [CodeW-1:0] CODE_OFFLINE  = 3'd6;

    typedef struct packed {
        logic [ModeW-1:0]  mode;
        logic [TimeW-1:0]  now_ms;
        logic [MoistW-1:0] soil_moisture;
        logic              water_available;
        logic              link_up;
        logic              cmd_water;
        logic              cmd_stop;
    } item_t;

    typedef struct packed {
        logic [CodeW-1:0] fsm_state_out;
        logic             pump_drive;
        logic             pump_running_flag;
        logic             water_empty_flag;
    } result_t;

    typedef struct packed {
        logic [MoistW-1:0] dry_level;
        logic [MoistW-1:0] wet_level;
        logic [TimeW-1:0]  run_limit;
        logic [TimeW-1:0]  rest_limit;
    } cfg_t;

    function automatic logic [CodeW-1:0] state_code(input state_t st);
        logic [CodeW-1:0] code;
        unique case (st)
            ST_INIT:     code = CODE_INIT;
            ST_MONITOR:  code = CODE_MONITOR;
            ST_AUTO:     code = CODE_AUTO;
            ST_MANUAL:   code = CODE_MANUAL;
            ST_COOLDOWN: code = CODE_COOLDOWN;
            ST_ALARM:    code = CODE_ALARM;
            ST_OFFLINE:  code = CODE_OFFLINE;
            default:     code = CODE_INIT;
        endcase
        return code;
    endfunction

endpackage

### design/ipf_cfg_regs.sv
// configuration register file for thresholds and timeouts
module ipf_cfg_regs
    import ipf_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_valid,
    input  logic [CfgIdxW-1:0]  cfg_index,
    input  logic [CfgDataW-1:0] cfg_data,
    output logic                cfg_ready,
    output cfg_t                cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_MOIST_LOW:    cfg_next.dry_level  = cfg_data[MoistW-1:0];
                CFG_MOIST_HIGH:   cfg_next.wet_level  = cfg_data[MoistW-1:0];
                CFG_PUMP_TIMEOUT: cfg_next.run_limit  = cfg_data[TimeW-1:0];
                CFG_COOLDOWN:     cfg_next.rest_limit = cfg_data[TimeW-1:0];
                default:          cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.dry_level  <= MOIST_LOW_RST;
            cfg_reg.wet_level  <= MOIST_HIGH_RST;
            cfg_reg.run_limit  <= PUMP_TIMEOUT_RST;
            cfg_reg.rest_limit <= COOLDOWN_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

### design/ipf_in_stage.sv
// input register holding one item until the controller takes it
module ipf_in_stage
    import ipf_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  load,
    input  logic  drain,
    input  item_t item_in,
    output logic  item_valid,
    output item_t item_out
);

    logic  valid_reg;
    logic  valid_next;
    item_t item_reg;

    assign item_valid = valid_reg;
    assign item_out   = item_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
            valid_next = 1'b1;
        else if (drain)
            valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (load)
            item_reg <= item_in;
    end

endmodule

### design/ipf_step.sv
// controller state and next-state logic applied once per item
module ipf_step
    import ipf_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    commit,
    input  item_t   item,
    input  cfg_t    cfg,
    output result_t result
);

    state_t           state_reg;
    state_t           state_next;
    logic [TimeW-1:0] entry_reg;
    logic [TimeW-1:0] entry_next;
    logic             pump_reg;
    logic             pump_next;
    logic             run_reg;
    logic             run_next;
    logic             empty_reg;
    logic             empty_next;

    logic [TimeW-1:0] elapsed;
    logic             dry;
    logic             pump_expired;
    logic             cool_done;
    logic             go;
    state_t           go_state;

    assign elapsed      = item.now_ms - entry_reg;
    assign dry          = item.soil_moisture < cfg.dry_level;
    assign pump_expired = elapsed >= cfg.run_limit;
    assign cool_done    = elapsed >= cfg.rest_limit;

    always_comb
    begin
        go         = 1'b0;
        go_state   = state_reg;
        state_next = state_reg;
        entry_next = entry_reg;
        pump_next  = pump_reg;
        run_next   = run_reg;
        empty_next = empty_reg;

        unique case (item.mode)
            MODE_UPDATE:
            begin
                unique case (state_reg)
                    ST_INIT:
                    begin
                        go       = 1'b1;
                        go_state = ST_MONITOR;
                    end
                    ST_MONITOR:
                    begin
                        if (!item.link_up)
                        begin
                            go       = 1'b1;
                            go_state = ST_OFFLINE;
                        end
                        else if (dry && item.water_available)
                        begin
                            go       = 1'b1;
                            go_state = ST_AUTO;
                        end
                        else if (item.cmd_water)
                        begin
                            go       = 1'b1;
                            go_state = ST_MANUAL;
                        end
                        else if (dry)
                        begin
                            go       = 1'b1;
                            go_state = ST_ALARM;
                        end
                    end
                    ST_AUTO:
                    begin
                        if (pump_expired || !item.water_available)
                        begin
                            go       = 1'b1;
                            go_state = ST_ALARM;
                        end
                        else if (item.soil_moisture >= cfg.wet_level)
                        begin
                            go       = 1'b1;
                            go_state = ST_COOLDOWN;
                        end
                    end
                    ST_MANUAL:
                    begin
                        if (pump_expired || !item.water_available)
                        begin
                            go       = 1'b1;
                            go_state = ST_ALARM;
                        end
                        else if (item.cmd_stop)
                        begin
                            go       = 1'b1;
                            go_state = ST_COOLDOWN;
                        end
                    end
                    ST_COOLDOWN:
                    begin
                        if (cool_done)
                        begin
                            go       = 1'b1;
                            go_state = ST_MONITOR;
                        end
                    end
                    ST_ALARM:
                    begin
                        if (item.cmd_stop)
                        begin
                            empty_next = 1'b0;
                            go         = 1'b1;
                            go_state   = ST_MONITOR;
                        end
                    end
                    ST_OFFLINE:
                    begin
                        if (item.link_up)
                        begin
                            go       = 1'b1;
                            go_state = ST_MONITOR;
                        end
                        else
                        begin
                            pump_next = (dry && item.water_available) || item.cmd_water;
                        end
                    end
                    default:
                    begin
                        go = 1'b0;
                    end
                endcase
            end
            MODE_ENTER_ALARM:
            begin
                if (state_reg != ST_ALARM)
                begin
                    go       = 1'b1;
                    go_state = ST_ALARM;
                end
            end
            MODE_START_MANUAL:
            begin
                if (state_reg == ST_MONITOR)
                begin
                    go       = 1'b1;
                    go_state = ST_MANUAL;
                end
            end
            MODE_STOP_MANUAL:
            begin
                if (state_reg == ST_MANUAL)
                begin
                    go       = 1'b1;
                    go_state = ST_COOLDOWN;
                end
            end
            MODE_CLEAR_ALARM:
            begin
                empty_next = 1'b0;
                go         = 1'b1;
                go_state   = ST_MONITOR;
            end
            default:
            begin
                go = 1'b0;
            end
        endcase

        if (go)
        begin
            state_next = go_state;
            entry_next = item.now_ms;
            unique case (go_state)
                ST_AUTO, ST_MANUAL:
                begin
                    pump_next = 1'b1;
                    run_next  = 1'b1;
                end
                ST_INIT, ST_MONITOR, ST_COOLDOWN:
                begin
                    pump_next = 1'b0;
                    run_next  = 1'b0;
                end
                ST_ALARM:
                begin
                    pump_next  = 1'b0;
                    run_next   = 1'b0;
                    empty_next = 1'b1;
                end
                ST_OFFLINE:
                begin
                    pump_next = pump_reg;
                end
                default:
                begin
                    pump_next = pump_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_INIT;
            entry_reg <= '0;
            pump_reg  <= 1'b0;
            run_reg   <= 1'b0;
            empty_reg <= 1'b0;
        end
        else if (commit)
        begin
            state_reg <= state_next;
            entry_reg <= entry_next;
            pump_reg  <= pump_next;
            run_reg   <= run_next;
            empty_reg <= empty_next;
        end
    end

    assign result.fsm_state_out     = state_code(state_next);
    assign result.pump_drive        = pump_next;
    assign result.pump_running_flag = run_next;
    assign result.water_empty_flag  = empty_next;

    // pump only runs while watering or offline
    assert property (@(posedge clk) disable iff (!rst_n)
        pump_reg |-> (state_reg == ST_AUTO || state_reg == ST_MANUAL ||
                      state_reg == ST_OFFLINE))
        else $error("pump on in a state that must keep it off");

    // running flag tracks the watering states
    assert property (@(posedge clk) disable iff (!rst_n)
        run_reg |-> (state_reg == ST_AUTO || state_reg == ST_MANUAL))
        else $error("running flag set outside watering");

    // empty flag is set exactly while in alarm
    assert property (@(posedge clk) disable iff (!rst_n)
        empty_reg == (state_reg == ST_ALARM))
        else $error("empty flag out of step with alarm state");

    // entry time only moves when an item is applied
    assert property (@(posedge clk) disable iff (!rst_n)
        !commit |=> $stable(entry_reg))
        else $error("entry time changed without an item");

endmodule

### design/ipf_out_stage.sv
// result register holding one result until the consumer takes it
module ipf_out_stage
    import ipf_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    load,
    input  logic    taken,
    input  result_t result_in,
    output logic    result_valid,
    output result_t result_out
);

    logic    valid_reg;
    logic    valid_next;
    result_t result_reg;

    assign result_valid = valid_reg;
    assign result_out   = result_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
            valid_next = 1'b1;
        else if (taken)
            valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (load)
            result_reg <= result_in;
    end

endmodule

### design/irrigation_pump_fsm.sv
// top level of the irrigation pump controller
//
//   channel  direction  handshake          payload
//   in       sink       in_valid/in_stall  mode, now_ms, soil_moisture, water_available,
//                                          link_up, cmd_water, cmd_stop
//   out      source     out_valid/out_stall fsm_state_out, pump_drive,
//                                          pump_running_flag, water_empty_flag
//   cfg      sink       cfg_valid/cfg_ready cfg_index, cfg_data
//
// one item per cycle unless a result stalls; items pass the input then the result register
// the state update is one compare-and-subtract pass between the input and result registers
// reset clears state to init, pump off, flags clear and thresholds to defaults
// a stalled result holds the result register; the input register then fills and in_stall rises
// cfg_ready is always high
module irrigation_pump_fsm
    import ipf_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic [ModeW-1:0]    mode,
    input  logic [TimeW-1:0]    now_ms,
    input  logic [MoistW-1:0]   soil_moisture,
    input  logic                water_available,
    input  logic                link_up,
    input  logic                cmd_water,
    input  logic                cmd_stop,
    output logic                out_valid,
    input  logic                out_stall,
    output logic [CodeW-1:0]    fsm_state_out,
    output logic                pump_drive,
    output logic                pump_running_flag,
    output logic                water_empty_flag,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [CfgIdxW-1:0]  cfg_index,
    input  logic [CfgDataW-1:0] cfg_data
);

    cfg_t    cfg;
    item_t   item_in;
    item_t   item_held;
    logic    item_held_valid;
    logic    out_free;
    logic    advance;
    logic    in_accept;
    result_t step_result;
    result_t out_result;

    assign item_in.mode            = mode;
    assign item_in.now_ms          = now_ms;
    assign item_in.soil_moisture   = soil_moisture;
    assign item_in.water_available = water_available;
    assign item_in.link_up         = link_up;
    assign item_in.cmd_water       = cmd_water;
    assign item_in.cmd_stop        = cmd_stop;

    assign out_free  = !out_valid || !out_stall;
    assign advance   = item_held_valid && out_free;
    assign in_stall  = item_held_valid && !out_free;
    assign in_accept = in_valid && !in_stall;

    ipf_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg_ready (cfg_ready),
        .cfg       (cfg)
    );

    ipf_in_stage u_in (
        .clk        (clk),
        .rst_n      (rst_n),
        .load       (in_accept),
        .drain      (advance),
        .item_in    (item_in),
        .item_valid (item_held_valid),
        .item_out   (item_held)
    );

    ipf_step u_step (
        .clk    (clk),
        .rst_n  (rst_n),
        .commit (advance),
        .item   (item_held),
        .cfg    (cfg),
        .result (step_result)
    );

    ipf_out_stage u_out (
        .clk          (clk),
        .rst_n        (rst_n),
        .load         (advance),
        .taken        (!out_stall),
        .result_in    (step_result),
        .result_valid (out_valid),
        .result_out   (out_result)
    );

    assign fsm_state_out     = out_result.fsm_state_out;
    assign pump_drive        = out_result.pump_drive;
    assign pump_running_flag = out_result.pump_running_flag;
    assign water_empty_flag  = out_result.water_empty_flag;

    // input side only backs up behind a stalled result
    assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (out_valid && out_stall && item_held_valid))
        else $error("input stalled without a blocked result");

    // a held item moves on whenever the result register can take it
    assert property (@(posedge clk) disable iff (!rst_n)
        (item_held_valid && !out_valid) |=> out_valid)
        else $error("held item did not reach the result register");

    // an accepted item sits in the input register next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        in_accept |=> item_held_valid)
        else $error("accepted item lost");

endmodule

### test/tb_irrigation_pump_fsm.sv
// self-checking testbench for the irrigation pump controller
module tb_irrigation_pump_fsm;
    import ipf_pkg::*;

    localparam logic [ModeW-1:0] MODE_UNUSED_FIRST = 3'd5;
    localparam int ITEMS_PER_PHASE = 320;
    localparam int NUM_PHASES = 6;
    localparam int HOLD_CYCLES = 300;
    localparam int DRAIN_LIMIT = 2000;

    class pump_scoreboard;
        logic [MoistW-1:0] moist_low;
        logic [MoistW-1:0] moist_high;
        logic [TimeW-1:0]  pump_limit;
        logic [TimeW-1:0]  rest_time;
        logic [CodeW-1:0]  st;
        logic [TimeW-1:0]  entered_at;
        logic              pump;
        logic              running;
        logic              empty;
        result_t           expected_q[$];
        int                failures;

        function new();
            moist_low  = MOIST_LOW_RST;
            moist_high = MOIST_HIGH_RST;
            pump_limit = PUMP_TIMEOUT_RST;
            rest_time  = COOLDOWN_RST;
            st         = CODE_INIT;
            entered_at = '0;
            pump       = 1'b0;
            running    = 1'b0;
            empty      = 1'b0;
            failures   = 0;
        endfunction

        function void write_cfg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
            case (idx)
                CFG_MOIST_LOW:    moist_low  = data[MoistW-1:0];
                CFG_MOIST_HIGH:   moist_high = data[MoistW-1:0];
                CFG_PUMP_TIMEOUT: pump_limit = data[TimeW-1:0];
                CFG_COOLDOWN:     rest_time  = data[TimeW-1:0];
                default: ;
            endcase
        endfunction

        function void enter(input logic [CodeW-1:0] next, input logic [TimeW-1:0] now);
            st = next;
            entered_at = now;
            case (next)
                CODE_AUTO, CODE_MANUAL:
                begin
                    pump = 1'b1;
                    running = 1'b1;
                end
                CODE_INIT, CODE_MONITOR, CODE_COOLDOWN:
                begin
                    pump = 1'b0;
                    running = 1'b0;
                end
                CODE_ALARM:
                begin
                    pump = 1'b0;
                    running = 1'b0;
                    empty = 1'b1;
                end
                default: ;
            endcase
        endfunction

        function void clear_alarm(input logic [TimeW-1:0] now);
            pump = 1'b0;
            empty = 1'b0;
            enter(CODE_MONITOR, now);
        endfunction

        function void note_item(input item_t it);
            logic [TimeW-1:0] elapsed;
            logic             dry;
            result_t          r;
            elapsed = it.now_ms - entered_at;
            dry = it.soil_moisture < moist_low;
            case (it.mode)
                MODE_UPDATE:
                begin
                    case (st)
                        CODE_INIT: enter(CODE_MONITOR, it.now_ms);
                        CODE_MONITOR:
                        begin
                            if (!it.link_up) enter(CODE_OFFLINE, it.now_ms);
                            else if (dry && it.water_available) enter(CODE_AUTO, it.now_ms);
                            else if (it.cmd_water) enter(CODE_MANUAL, it.now_ms);
                            else if (dry) enter(CODE_ALARM, it.now_ms);
                        end
                        CODE_AUTO:
                        begin
                            if (elapsed >= pump_limit || !it.water_available)
                                enter(CODE_ALARM, it.now_ms);
                            else if (it.soil_moisture >= moist_high)
                                enter(CODE_COOLDOWN, it.now_ms);
                        end
                        CODE_MANUAL:
                        begin
                            if (elapsed >= pump_limit || !it.water_available)
                                enter(CODE_ALARM, it.now_ms);
                            else if (it.cmd_stop)
                                enter(CODE_COOLDOWN, it.now_ms);
                        end
                        CODE_COOLDOWN:
                        begin
                            if (elapsed >= rest_time) enter(CODE_MONITOR, it.now_ms);
                        end
                        CODE_ALARM:
                        begin
                            if (it.cmd_stop) clear_alarm(it.now_ms);
                        end
                        CODE_OFFLINE:
                        begin
                            if (it.link_up) enter(CODE_MONITOR, it.now_ms);
                            else pump = (dry && it.water_available) || it.cmd_water;
                        end
                        default: ;
                    endcase
                end
                MODE_ENTER_ALARM:
                begin
                    if (st != CODE_ALARM) enter(CODE_ALARM, it.now_ms);
                end
                MODE_START_MANUAL:
                begin
                    if (st == CODE_MONITOR) enter(CODE_MANUAL, it.now_ms);
                end
                MODE_STOP_MANUAL:
                begin
                    if (st == CODE_MANUAL) enter(CODE_COOLDOWN, it.now_ms);
                end
                MODE_CLEAR_ALARM: clear_alarm(it.now_ms);
                default: ;
            endcase
            r.fsm_state_out = st;
            r.pump_drive = pump;
            r.pump_running_flag = running;
            r.water_empty_flag = empty;
            expected_q.push_back(r);
        endfunction

        function void check_result(input result_t got);
            result_t want;
            if (expected_q.size() == 0)
            begin
                failures++;
                if (failures <= 10)
                    $display("unexpected result: state %0d pump %0b running %0b empty %0b",
                             got.fsm_state_out, got.pump_drive, got.pump_running_flag,
                             got.water_empty_flag);
                return;
            end
            want = expected_q.pop_front();
            if (got.fsm_state_out !== want.fsm_state_out || got.pump_drive !== want.pump_drive
                || got.pump_running_flag !== want.pump_running_flag
                || got.water_empty_flag !== want.water_empty_flag)
            begin
                failures++;
                if (failures <= 10)
                    $display("exp/act state %0d/%0d pump %0b/%0b run %0b/%0b empty %0b/%0b",
                             want.fsm_state_out, got.fsm_state_out,
                             want.pump_drive, got.pump_drive,
                             want.pump_running_flag, got.pump_running_flag,
                             want.water_empty_flag, got.water_empty_flag);
            end
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                in_valid = 1'b0;
    logic                in_stall;
    logic [ModeW-1:0]    mode = '0;
    logic [TimeW-1:0]    now_ms = '0;
    logic [MoistW-1:0]   soil_moisture = '0;
    logic                water_available = 1'b0;
    logic                link_up = 1'b0;
    logic                cmd_water = 1'b0;
    logic                cmd_stop = 1'b0;
    logic                out_valid;
    logic                out_stall = 1'b0;
    logic [CodeW-1:0]    fsm_state_out;
    logic                pump_drive;
    logic                pump_running_flag;
    logic                water_empty_flag;
    logic                cfg_valid = 1'b0;
    logic                cfg_ready;
    logic [CfgIdxW-1:0]  cfg_index = '0;
    logic [CfgDataW-1:0] cfg_data = '0;

    pump_scoreboard sb = new();

    logic [TimeW-1:0] clock_ms = '0;
    int unsigned      step_max = 20000;
    int               link_pct = 92;
    bit               idle_en = 1'b1;
    bit               hold_request = 1'b0;
    int               hold_left = 0;

    irrigation_pump_fsm i_dut (.*);

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    initial
    begin
        #2000000;
        $display("Verification failed");
        $finish;
    end

    // receiver side: random stalls, plus one long hold-off on request
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (hold_left > 0)
            begin
                out_stall <= 1'b1;
                hold_left--;
            end
            else if (hold_request)
            begin
                hold_request = 1'b0;
                hold_left = HOLD_CYCLES - 1;
                out_stall <= 1'b1;
            end
            else
                out_stall <= idle_en && ($urandom_range(99) < 31);
        end
    end

    always @(posedge clk)
    begin : monitor
        result_t shown;
        item_t   taken_item;
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                shown.fsm_state_out = fsm_state_out;
                shown.pump_drive = pump_drive;
                shown.pump_running_flag = pump_running_flag;
                shown.water_empty_flag = water_empty_flag;
                sb.check_result(shown);
            end
            if (in_valid && !in_stall)
            begin
                taken_item.mode = mode;
                taken_item.now_ms = now_ms;
                taken_item.soil_moisture = soil_moisture;
                taken_item.water_available = water_available;
                taken_item.link_up = link_up;
                taken_item.cmd_water = cmd_water;
                taken_item.cmd_stop = cmd_stop;
                sb.note_item(taken_item);
            end
            if (cfg_valid && cfg_ready)
                sb.write_cfg(cfg_index, cfg_data);
        end
    end

    task automatic send_item(input item_t it);
        logic taken;
        while (idle_en && $urandom_range(99) < 31)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        mode <= it.mode;
        now_ms <= it.now_ms;
        soil_moisture <= it.soil_moisture;
        water_available <= it.water_available;
        link_up <= it.link_up;
        cmd_water <= it.cmd_water;
        cmd_stop <= it.cmd_stop;
        do
        begin
            @(negedge clk);
            taken = !in_stall;
            @(posedge clk);
        end
        while (!taken);
    endtask

    task automatic send_fields(input logic [ModeW-1:0] md, input logic [TimeW-1:0] dt,
                               input int moist, input logic water, input logic link,
                               input logic cw, input logic cs);
        item_t it;
        clock_ms += dt;
        it.mode = md;
        it.now_ms = clock_ms;
        it.soil_moisture = moist[MoistW-1:0];
        it.water_available = water;
        it.link_up = link;
        it.cmd_water = cw;
        it.cmd_stop = cs;
        send_item(it);
    endtask

    task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
        logic taken;
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        do
        begin
            @(negedge clk);
            taken = cfg_ready;
            @(posedge clk);
        end
        while (!taken);
    endtask

    task automatic wait_drained();
        int n;
        n = 0;
        do
        begin
            @(posedge clk);
            n++;
        end
        while (sb.pending() != 0 && n < DRAIN_LIMIT);
    endtask

    function automatic item_t random_item();
        item_t it;
        int    pick;
        int    level;
        pick = $urandom_range(99);
        if (pick < 60) it.mode = MODE_UPDATE;
        else if (pick < 68) it.mode = MODE_ENTER_ALARM;
        else if (pick < 78) it.mode = MODE_START_MANUAL;
        else if (pick < 86) it.mode = MODE_STOP_MANUAL;
        else if (pick < 96) it.mode = MODE_CLEAR_ALARM;
        else it.mode = MODE_UNUSED_FIRST + ModeW'($urandom_range(2));
        if ($urandom_range(99) < 3) clock_ms = $urandom();
        else clock_ms += $urandom_range(step_max);
        it.now_ms = clock_ms;
        // readings near the thresholds hit the compare boundaries
        if ($urandom_range(99) < 35)
        begin
            level = $urandom_range(1) ? int'(sb.moist_low) : int'(sb.moist_high);
            level += int'($urandom_range(2)) - 1;
            if (level < 0) level = 0;
            if (level > 100) level = 100;
        end
        else
            level = $urandom_range(100);
        it.soil_moisture = level[MoistW-1:0];
        it.water_available = $urandom_range(99) < 88;
        it.link_up = $urandom_range(99) < link_pct;
        it.cmd_water = $urandom_range(99) < 25;
        it.cmd_stop = $urandom_range(99) < 20;
        return it;
    endfunction

    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed pass through every state and event at reset thresholds
        send_fields(MODE_UPDATE, 0, 50, 1, 1, 0, 0);
        send_fields(MODE_UPDATE, 5, 100, 1, 1, 0, 0);
        send_fields(MODE_UNUSED_FIRST, 1, 0, 1, 1, 1, 1);
        send_fields(MODE_UPDATE, 5, 0, 1, 1, 0, 0);
        send_fields(MODE_UPDATE, 59999, 50, 1, 1, 0, 0);
        send_fields(MODE_UPDATE, 1, 50, 1, 1, 0, 0);
        send_fields(MODE_UPDATE, 1, 50, 1, 1, 0, 1);
        send_fields(MODE_START_MANUAL, 1, 50, 1, 1, 0, 0);
        send_fields(MODE_UPDATE, 1, 50, 0, 1, 0, 0);
        send_fields(MODE_ENTER_ALARM, 1, 50, 1, 1, 0, 0);
        send_fields(MODE_CLEAR_ALARM, 1, 50, 1, 1, 0, 0);
        send_fields(MODE_UPDATE, 1, 50, 1, 0, 0, 0);
        send_fields(MODE_UPDATE, 1, 10, 1, 0, 0, 0);
        send_fields(MODE_UPDATE, 1, 100, 0, 0, 1, 0);
        send_fields(MODE_UPDATE, 1, 100, 1, 0, 0, 0);
        send_fields(MODE_UPDATE, 1, 50, 1, 1, 0, 0);
        send_fields(MODE_UPDATE, 1, 100, 1, 1, 1, 0);
        clock_ms = '1;
        send_fields(MODE_STOP_MANUAL, 0, 100, 1, 1, 0, 0);
        send_fields(MODE_UPDATE, 299999, 100, 1, 1, 0, 0);
        send_fields(MODE_UPDATE, 1, 100, 1, 1, 0, 0);
        send_fields(MODE_UPDATE, 1, 29, 0, 1, 0, 0);
        send_fields(MODE_START_MANUAL, 1, 29, 0, 1, 0, 0);
        send_fields(MODE_STOP_MANUAL, 1, 29, 0, 1, 0, 0);
        send_fields(MODE_UPDATE, 1, 0, 1, 1, 0, 1);
        send_fields(MODE_UPDATE, 1, 0, 1, 1, 0, 0);
        send_fields(MODE_UPDATE, 1, 70, 1, 1, 0, 0);
        send_fields(MODE_ENTER_ALARM, 1, 70, 1, 1, 0, 0);
        in_valid <= 1'b0;

        for (int p = 0; p < NUM_PHASES; p++)
        begin
            wait_drained();
            step_max = 20000;
            link_pct = 92;
            idle_en = 1'b1;
            case (p)
                1:
                begin
                    idle_en = 1'b0;
                    step_max = 50;
                    write_reg(CFG_MOIST_LOW, 32'd0);
                    write_reg(CFG_MOIST_HIGH, 32'd100);
                    write_reg(CFG_PUMP_TIMEOUT, 32'd0);
                    write_reg(CFG_COOLDOWN, 32'd0);
                end
                2:
                begin
                    step_max = 32'hFFFF_FFFF;
                    write_reg(CFG_MOIST_LOW, 32'd100);
                    write_reg(CFG_MOIST_HIGH, 32'd0);
                    write_reg(CFG_PUMP_TIMEOUT, 32'hFFFF_FFFF);
                    write_reg(CFG_COOLDOWN, 32'hFFFF_FFFF);
                end
                3:
                begin
                    step_max = 60;
                    clock_ms = 32'hFFFF_F000;
                    write_reg(CFG_MOIST_LOW, 32'd40);
                    write_reg(CFG_MOIST_HIGH, 32'd60);
                    write_reg(CFG_PUMP_TIMEOUT, 32'd200);
                    write_reg(CFG_COOLDOWN, 32'd300);
                    hold_request = 1'b1;
                end
                4:
                begin
                    step_max = 80;
                    link_pct = 60;
                    write_reg(CFG_MOIST_LOW, $urandom_range(100));
                    write_reg(CFG_MOIST_HIGH, $urandom_range(100));
                    write_reg(CFG_PUMP_TIMEOUT, $urandom_range(500));
                    write_reg(CFG_COOLDOWN, $urandom_range(500));
                end
                5:
                begin
                    step_max = 3;
                    write_reg(CFG_MOIST_LOW, 32'd50);
                    write_reg(CFG_MOIST_HIGH, 32'd50);
                    write_reg(CFG_PUMP_TIMEOUT, 32'd1);
                    write_reg(CFG_COOLDOWN, 32'd1);
                end
                default: ;
            endcase
            cfg_valid <= 1'b0;
            repeat (ITEMS_PER_PHASE) send_item(random_item());
            in_valid <= 1'b0;
        end

        wait_drained();
        repeat (4) @(posedge clk);
        if (sb.failures == 0 && sb.pending() == 0)
            $display("Verification passed");
        else
        begin
            if (sb.pending() != 0)
                $display("%0d expected results never arrived", sb.pending());
            $display("Verification failed");
        end
        $finish;
    end

endmodule
